// File: rtl/tcpb_pkg.sv
// -----------------------------------------------------------------------------
// tcpb_pkg
// Types and constants shared by the TCP header builder with checksum.
// -----------------------------------------------------------------------------
package tcpb_pkg;

   typedef enum logic {
      OP_HDR  = 1'b0,
      OP_DATA = 1'b1
   } op_kind_type;

   // one classified request handed from the front to the back
   typedef struct packed {
      op_kind_type kind;
      logic        last;
      logic        with_mss;
      logic [15:0] data_word;
      logic [31:0] src_addr;
      logic [31:0] dst_addr;
      logic [15:0] src_port;
      logic [15:0] dst_port;
      logic [31:0] seq_num;
      logic [31:0] ack_num;
      logic [7:0]  tcp_flags;
      logic [15:0] window;
      logic [15:0] mss;
      logic [15:0] payload_len;
   } op_type;

   typedef struct packed {
      logic        last;
      logic [15:0] word;
   } rsp_type;

   localparam int          SYN_BIT     = 1;
   localparam int          HDR_WORDS   = 12;
   localparam logic [15:0] PROTO_TCP   = 16'd6;
   localparam logic [15:0] BASE_HLEN   = 16'd20;
   localparam logic [15:0] OPT_HLEN    = 16'd4;
   localparam logic [15:0] MSS_OPT_HDR = 16'h0204;
   localparam logic [15:0] ODD_MASK    = 16'hff00;
   localparam logic [15:0] ALL_ONES    = 16'hffff;
   localparam logic [3:0]  DOFF_BASE   = 4'd5;
   localparam logic [3:0]  DOFF_MSS    = 4'd6;
   localparam logic [4:0]  WORDS_BASE  = 5'd10;
   localparam logic [4:0]  WORDS_MSS   = 5'd12;
   localparam logic [4:0]  CK_WORD_IDX = 5'd8;

endpackage

// File: rtl/tcpb_queue.sv
// -----------------------------------------------------------------------------
// tcpb_queue
// Small first-word-fall-through queue of packed entries.
// -----------------------------------------------------------------------------
module tcpb_queue #(
   parameter int WIDTH = 17,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] wr_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] rd_data,
   output logic             empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(DEPTH);

   logic [WIDTH-1:0] entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full    = (count_ff == DEPTH_CNT);
   assign empty   = (count_ff == '0);
   assign rd_data = entry_ff[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= wr_data;
      end
   end

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= DEPTH_CNT)
      else $error("queue count above depth");
`endif

endmodule

// File: rtl/tcpb_front.sv
// -----------------------------------------------------------------------------
// tcpb_front
// Accepts requests, tracks the payload still expected and classifies each
// request as a header op or a payload op; stray payload words are dropped.
// -----------------------------------------------------------------------------
module tcpb_front #(
   parameter int MAX_PAYLOAD = 65515
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           req_push,
   output logic           req_full,
   input  logic           req_kind,
   input  logic [31:0]    req_src_addr,
   input  logic [31:0]    req_dst_addr,
   input  logic [15:0]    req_src_port,
   input  logic [15:0]    req_dst_port,
   input  logic [31:0]    req_seq_num,
   input  logic [31:0]    req_ack_num,
   input  logic [7:0]     req_tcp_flags,
   input  logic [15:0]    req_window,
   input  logic [15:0]    req_mss,
   input  logic [15:0]    req_payload_len,
   input  logic [15:0]    req_data_word,
   output tcpb_pkg::op_type op,
   output logic           op_push,
   input  logic           op_full
);

   import tcpb_pkg::*;

   localparam logic [15:0] MAX_LEN = 16'(MAX_PAYLOAD);

   logic        collecting_ff, collecting_in;
   logic [15:0] bytes_left_ff, bytes_left_in;
   logic        accept;
   logic        is_hdr;
   logic [15:0] plen_sat;
   logic [15:0] left_next;
   logic [15:0] word_masked;

   assign req_full = op_full;
   assign accept   = req_push && !op_full;
   assign is_hdr   = (op_kind_type'(req_kind) == OP_HDR);
   assign plen_sat = (req_payload_len > MAX_LEN) ? MAX_LEN : req_payload_len;

   // an odd final byte keeps only the upper half
   always_comb begin
      if (bytes_left_ff >= 16'd2) begin
         left_next   = bytes_left_ff - 16'd2;
         word_masked = req_data_word;
      end else begin
         left_next   = '0;
         word_masked = req_data_word & ODD_MASK;
      end
   end

   always_comb begin
      op.kind        = op_kind_type'(req_kind);
      op.last        = is_hdr ? (plen_sat == '0) : (left_next == '0);
      op.with_mss    = req_tcp_flags[SYN_BIT] && (req_mss != '0);
      op.data_word   = word_masked;
      op.src_addr    = req_src_addr;
      op.dst_addr    = req_dst_addr;
      op.src_port    = req_src_port;
      op.dst_port    = req_dst_port;
      op.seq_num     = req_seq_num;
      op.ack_num     = req_ack_num;
      op.tcp_flags   = req_tcp_flags;
      op.window      = req_window;
      op.mss         = req_mss;
      op.payload_len = plen_sat;
   end

   assign op_push = accept && (is_hdr || collecting_ff);

   always_comb begin
      collecting_in = collecting_ff;
      bytes_left_in = bytes_left_ff;
      if (accept) begin
         if (is_hdr) begin
            bytes_left_in = plen_sat;
            collecting_in = (plen_sat != '0);
         end else if (collecting_ff) begin
            bytes_left_in = left_next;
            collecting_in = (left_next != '0);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         collecting_ff <= 1'b0;
         bytes_left_ff <= '0;
      end else begin
         collecting_ff <= collecting_in;
         bytes_left_ff <= bytes_left_in;
      end
   end

`ifndef SYNTHESIS
   a_collect_count: assert property (@(posedge clock) disable iff (reset)
      collecting_ff == (bytes_left_ff != '0))
      else $error("collecting flag disagrees with byte count");
`endif

endmodule

// File: rtl/tcpb_back.sv
// -----------------------------------------------------------------------------
// tcpb_back
// Holds the header words, runs the ones-complement sum one term per cycle
// and emits the finished header words with the checksum.
// -----------------------------------------------------------------------------
module tcpb_back (
   input  logic              clock,
   input  logic              reset,
   input  tcpb_pkg::op_type  op,
   input  logic              op_empty,
   output logic              op_pop,
   output tcpb_pkg::rsp_type rsp_out,
   output logic              rsp_push,
   input  logic              rsp_full
);

   import tcpb_pkg::*;

   typedef enum logic [1:0] {
      ST_WAIT,
      ST_SUM,
      ST_EMIT
   } state_type;

   // sum terms after the twelve header words
   localparam logic [4:0] TERM_SRC_HI = 5'd12;
   localparam logic [4:0] TERM_SRC_LO = 5'd13;
   localparam logic [4:0] TERM_DST_HI = 5'd14;
   localparam logic [4:0] TERM_DST_LO = 5'd15;
   localparam logic [4:0] TERM_LEN    = 5'd16;
   localparam logic [4:0] TERM_PROTO  = 5'd17;
   localparam logic [4:0] HDR_WORDS_W = 5'(HDR_WORDS);

   state_type   state_ff, state_in;
   logic [4:0]  idx_ff, idx_in;
   logic [16:0] sum_ff, sum_in;
   logic        with_mss_ff, with_mss_in;
   logic        last_ff, last_in;
   logic [31:0] src_ff, src_in;
   logic [31:0] dst_ff, dst_in;
   logic [15:0] len_ff, len_in;
   logic [15:0] hw_ff [HDR_WORDS];
   logic [15:0] hw_in [HDR_WORDS];

   logic [15:0] hw_rd;
   logic [15:0] sum_term;
   logic [15:0] add_term;
   logic [16:0] raw_sum;
   logic [16:0] folded;
   logic [15:0] fold16;
   logic [15:0] ck_raw;
   logic [15:0] ck;
   logic [4:0]  n_words;
   logic [15:0] hlen;

   assign hw_rd = (idx_ff < HDR_WORDS_W) ? hw_ff[idx_ff[3:0]] : '0;

   always_comb begin
      if (idx_ff < HDR_WORDS_W) begin
         sum_term = hw_rd;
      end else begin
         case (idx_ff)
            TERM_SRC_HI: sum_term = src_ff[31:16];
            TERM_SRC_LO: sum_term = src_ff[15:0];
            TERM_DST_HI: sum_term = dst_ff[31:16];
            TERM_DST_LO: sum_term = dst_ff[15:0];
            TERM_LEN:    sum_term = len_ff;
            TERM_PROTO:  sum_term = PROTO_TCP;
            default:     sum_term = '0;
         endcase
      end
   end

   // end-around carry add, sum stays at or below 0x10000
   assign add_term = (state_ff == ST_SUM) ? sum_term : op.data_word;
   assign raw_sum  = sum_ff + {1'b0, add_term};
   assign folded   = {1'b0, raw_sum[15:0]} + {16'b0, raw_sum[16]};

   assign fold16  = sum_ff[15:0] + {15'b0, sum_ff[16]};
   assign ck_raw  = ~fold16;
   assign ck      = (ck_raw == '0) ? ALL_ONES : ck_raw;
   assign n_words = with_mss_ff ? WORDS_MSS : WORDS_BASE;
   assign hlen    = op.with_mss ? (BASE_HLEN + OPT_HLEN) : BASE_HLEN;

   assign op_pop       = (state_ff == ST_WAIT) && !op_empty;
   assign rsp_push     = (state_ff == ST_EMIT) && !rsp_full;
   assign rsp_out.word = (idx_ff == CK_WORD_IDX) ? ck : hw_rd;
   assign rsp_out.last = (idx_ff == n_words - 5'd1);

   always_comb begin
      state_in    = state_ff;
      idx_in      = idx_ff;
      sum_in      = sum_ff;
      with_mss_in = with_mss_ff;
      last_in     = last_ff;
      src_in      = src_ff;
      dst_in      = dst_ff;
      len_in      = len_ff;
      hw_in       = hw_ff;
      case (state_ff)
         ST_WAIT: begin
            if (!op_empty) begin
               if (op.kind == OP_HDR) begin
                  hw_in[0]    = op.src_port;
                  hw_in[1]    = op.dst_port;
                  hw_in[2]    = op.seq_num[31:16];
                  hw_in[3]    = op.seq_num[15:0];
                  hw_in[4]    = op.ack_num[31:16];
                  hw_in[5]    = op.ack_num[15:0];
                  hw_in[6]    = {(op.with_mss ? DOFF_MSS : DOFF_BASE), 4'b0, op.tcp_flags};
                  hw_in[7]    = op.window;
                  hw_in[8]    = '0;
                  hw_in[9]    = '0;
                  hw_in[10]   = op.with_mss ? MSS_OPT_HDR : '0;
                  hw_in[11]   = op.with_mss ? op.mss : '0;
                  with_mss_in = op.with_mss;
                  last_in     = op.last;
                  src_in      = op.src_addr;
                  dst_in      = op.dst_addr;
                  len_in      = hlen + op.payload_len;
                  sum_in      = '0;
                  idx_in      = '0;
                  state_in    = ST_SUM;
               end else begin
                  sum_in = folded;
                  if (op.last) begin
                     idx_in   = '0;
                     state_in = ST_EMIT;
                  end
               end
            end
         end
         ST_SUM: begin
            sum_in = folded;
            if (idx_ff == TERM_PROTO) begin
               idx_in   = '0;
               state_in = last_ff ? ST_EMIT : ST_WAIT;
            end else begin
               idx_in = idx_ff + 5'd1;
            end
         end
         ST_EMIT: begin
            if (!rsp_full) begin
               if (rsp_out.last) begin
                  idx_in   = '0;
                  state_in = ST_WAIT;
               end else begin
                  idx_in = idx_ff + 5'd1;
               end
            end
         end
         default: begin
            state_in = ST_WAIT;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_WAIT;
         idx_ff      <= '0;
         sum_ff      <= '0;
         with_mss_ff <= 1'b0;
         last_ff     <= 1'b0;
      end else begin
         state_ff    <= state_in;
         idx_ff      <= idx_in;
         sum_ff      <= sum_in;
         with_mss_ff <= with_mss_in;
         last_ff     <= last_in;
      end
      src_ff <= src_in;
      dst_ff <= dst_in;
      len_ff <= len_in;
      hw_ff  <= hw_in;
   end

`ifndef SYNTHESIS
   a_sum_bound: assert property (@(posedge clock) disable iff (reset)
      sum_ff <= 17'h10000)
      else $error("running sum left its folded range");

   a_emit_index: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT) |-> (idx_ff < n_words))
      else $error("header word index past end of header");

   a_hdr_starts_sum: assert property (@(posedge clock) disable iff (reset)
      (op_pop && op.kind == OP_HDR) |=> (state_ff == ST_SUM && idx_ff == '0 && sum_ff == '0))
      else $error("header op did not restart the sum");
`endif

endmodule

// File: rtl/tcp_header_builder_checksum.sv
// Path: a header request with zero payload puts its first header word on the
// result ports via the op queue, the ST_SUM pass, ST_EMIT and the result queue;
// a final payload word via the op queue, ST_WAIT, ST_EMIT and the result queue.
// Throughput: payload words 1 per cycle in ST_WAIT; a header request holds the sum
// unit, then 10 or 12 words leave at 1 per cycle while the result queue has room.
// Reset: synchronous, clears queues and control; held header words stay unset.
// -----------------------------------------------------------------------------
// tcp_header_builder_checksum
// Builds TCP header words with the Internet checksum over pseudo header,
// header and payload words.
// -----------------------------------------------------------------------------
module tcp_header_builder_checksum #(
   parameter int MAX_PAYLOAD = 65515
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   output logic        req_full,
   input  logic        req_kind,
   input  logic [31:0] req_src_addr,
   input  logic [31:0] req_dst_addr,
   input  logic [15:0] req_src_port,
   input  logic [15:0] req_dst_port,
   input  logic [31:0] req_seq_num,
   input  logic [31:0] req_ack_num,
   input  logic [7:0]  req_tcp_flags,
   input  logic [15:0] req_window,
   input  logic [15:0] req_mss,
   input  logic [15:0] req_payload_len,
   input  logic [15:0] req_data_word,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic [15:0] rsp_header_word,
   output logic        rsp_last_word
);

   import tcpb_pkg::*;

   op_type  front_op;
   op_type  back_op;
   logic    op_push;
   logic    op_full;
   logic    op_pop;
   logic    op_empty;
   rsp_type back_rsp;
   rsp_type rsp_head;
   logic    rsp_push;
   logic    rsp_full;

   tcpb_front #(
      .MAX_PAYLOAD(MAX_PAYLOAD)
   ) u_front (
      .clock           (clock),
      .reset           (reset),
      .req_push        (req_push),
      .req_full        (req_full),
      .req_kind        (req_kind),
      .req_src_addr    (req_src_addr),
      .req_dst_addr    (req_dst_addr),
      .req_src_port    (req_src_port),
      .req_dst_port    (req_dst_port),
      .req_seq_num     (req_seq_num),
      .req_ack_num     (req_ack_num),
      .req_tcp_flags   (req_tcp_flags),
      .req_window      (req_window),
      .req_mss         (req_mss),
      .req_payload_len (req_payload_len),
      .req_data_word   (req_data_word),
      .op              (front_op),
      .op_push         (op_push),
      .op_full         (op_full)
   );

   tcpb_queue #(
      .WIDTH($bits(op_type)),
      .DEPTH(2)
   ) u_op_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (op_push),
      .wr_data (front_op),
      .full    (op_full),
      .pop     (op_pop),
      .rd_data (back_op),
      .empty   (op_empty)
   );

   tcpb_back u_back (
      .clock    (clock),
      .reset    (reset),
      .op       (back_op),
      .op_empty (op_empty),
      .op_pop   (op_pop),
      .rsp_out  (back_rsp),
      .rsp_push (rsp_push),
      .rsp_full (rsp_full)
   );

   tcpb_queue #(
      .WIDTH($bits(rsp_type)),
      .DEPTH(2)
   ) u_rsp_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (rsp_push),
      .wr_data (back_rsp),
      .full    (rsp_full),
      .pop     (rsp_pop),
      .rd_data (rsp_head),
      .empty   (rsp_empty)
   );

   assign rsp_header_word = rsp_head.word;
   assign rsp_last_word   = rsp_head.last;

endmodule
